FILE: hw/rtl/fqs_pkg.sv
`timescale 1ns / 1ps

package fqs_pkg;

	localparam int DEPTH  = 64;
	localparam int DATA_W = 32;
	localparam int REQ_W  = 2;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 7;
	localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SUM_W  = CNT_W + 1;

	localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
	localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;
	localparam logic [REQ_W-1:0] REQ_DUMP   = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOMATCH = 2'd3;

	typedef enum logic [3:0] {
		OP_PUSH   = 4'b0001,
		OP_POP    = 4'b0010,
		OP_SEARCH = 4'b0100,
		OP_DUMP   = 4'b1000
	} op_t;

	typedef struct packed {
		op_t                       op;
		logic signed [DATA_W-1:0]  value;
	} cmd_t;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] base,
		input logic [CNT_W-1:0] off);
		logic [SUM_W-1:0] s;
		s = SUM_W'(base) + SUM_W'(off);
		if (s >= SUM_W'(DEPTH)) begin
			s = s - SUM_W'(DEPTH);
		end
		return s[PTR_W-1:0];
	endfunction

endpackage

FILE: hw/rtl/fqs_ram.sv
`timescale 1ns / 1ps

module fqs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/fqs_front.sv
`timescale 1ns / 1ps

module fqs_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic [fqs_pkg::REQ_W-1:0]      req_type,
	input  logic signed [fqs_pkg::DATA_W-1:0] value,
	output logic                           cmd_valid,
	input  logic                           cmd_take,
	output fqs_pkg::cmd_t                  cmd
);
	import fqs_pkg::*;

	cmd_t       buf_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;
	cmd_t       dec;

	always_comb begin
		dec.value = value;
		case (req_type)
			REQ_PUSH:   dec.op = OP_PUSH;
			REQ_POP:    dec.op = OP_POP;
			REQ_SEARCH: dec.op = OP_SEARCH;
			REQ_DUMP:   dec.op = OP_DUMP;
			default:    dec.op = OP_PUSH;
		endcase
	end

	assign req_stall = (fill_q == 2'd2);
	assign push      = req_valid && !req_stall;
	assign pop       = cmd_take && cmd_valid;
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd       = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

FILE: hw/rtl/fqs_back.sv
`timescale 1ns / 1ps

module fqs_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	output logic                               cmd_take,
	input  fqs_pkg::cmd_t                      cmd,
	output logic                               ram_we,
	output logic [fqs_pkg::PTR_W-1:0]          ram_waddr,
	output logic [fqs_pkg::DATA_W-1:0]         ram_wdata,
	output logic                               ram_re,
	output logic [fqs_pkg::PTR_W-1:0]          ram_raddr,
	input  logic [fqs_pkg::DATA_W-1:0]         ram_rdata,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic [fqs_pkg::STAT_W-1:0]         status,
	output logic signed [fqs_pkg::DATA_W-1:0]  data,
	output logic [fqs_pkg::CNT_W-1:0]          position,
	output logic [fqs_pkg::CNT_W-1:0]          count,
	output logic                               last
);
	import fqs_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_POP   = 4'b0010,
		S_SCAN  = 4'b0100,
		S_FLUSH = 4'b1000
	} state_t;

	state_t              state_q;
	logic [PTR_W-1:0]    head_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    idx_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic                search_q;
	logic [DATA_W-1:0]   val_q;
	logic                held_v_q;
	logic [DATA_W-1:0]   held_data_q;
	logic [CNT_W-1:0]    held_pos_q;

	logic                out_valid_q;
	logic [STAT_W-1:0]   out_status_q;
	logic [DATA_W-1:0]   out_data_q;
	logic [CNT_W-1:0]    out_pos_q;
	logic [CNT_W-1:0]    out_cnt_q;
	logic                out_last_q;

	logic                ofree;
	logic                full;
	logic                empty;
	logic                match;
	logic                lastent;
	logic                scan_go;
	logic                emit;
	logic [STAT_W-1:0]   e_status;
	logic [DATA_W-1:0]   e_data;
	logic [CNT_W-1:0]    e_pos;
	logic [CNT_W-1:0]    e_cnt;
	logic                e_last;

	assign ofree     = !out_valid_q || !rsp_stall;
	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign empty     = (cnt_q == '0);
	assign match     = search_q && (ram_rdata == val_q);
	assign lastent   = ((idx_q + CNT_W'(1)) == cnt_q);
	assign ram_waddr = ptr_add(head_q, cnt_q);
	assign ram_wdata = cmd.value;

	always_comb begin
		cmd_take  = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = head_q;
		scan_go   = 1'b0;
		emit      = 1'b0;
		e_status  = ST_OK;
		e_data    = '0;
		e_pos     = '0;
		e_cnt     = cnt_q;
		e_last    = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid && ofree) begin
					cmd_take = 1'b1;
					case (cmd.op)
						OP_PUSH: begin
							emit = 1'b1;
							if (full) begin
								e_status = ST_FULL;
							end else begin
								ram_we = 1'b1;
								e_cnt  = cnt_q + CNT_W'(1);
							end
						end
						OP_POP, OP_SEARCH, OP_DUMP: begin
							if (empty) begin
								emit     = 1'b1;
								e_status = (cmd.op == OP_SEARCH) ? ST_NOMATCH : ST_EMPTY;
							end else begin
								ram_re = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			S_POP: begin
				if (ofree) begin
					emit   = 1'b1;
					e_data = ram_rdata;
					e_cnt  = cnt_q - CNT_W'(1);
				end
			end
			S_SCAN: begin
				if (!search_q) begin
					scan_go = ofree;
					emit    = ofree;
					e_data  = ram_rdata;
					e_pos   = idx_q + CNT_W'(1);
					e_last  = lastent;
				end else begin
					scan_go = !(match && held_v_q) || ofree;
					emit    = match && held_v_q && ofree;
					e_data  = held_data_q;
					e_pos   = held_pos_q;
					e_last  = 1'b0;
				end
				if (scan_go && !lastent) begin
					ram_re    = 1'b1;
					ram_raddr = ptr_inc(rd_ptr_q);
				end
			end
			S_FLUSH: begin
				if (ofree) begin
					emit = 1'b1;
					if (held_v_q) begin
						e_data = held_data_q;
						e_pos  = held_pos_q;
					end else begin
						e_status = ST_NOMATCH;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			rd_ptr_q    <= '0;
			search_q    <= 1'b0;
			held_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_take) begin
						case (cmd.op)
							OP_PUSH: begin
								if (!full) begin
									cnt_q <= cnt_q + CNT_W'(1);
								end
							end
							OP_POP: begin
								if (!empty) begin
									state_q <= S_POP;
								end
							end
							OP_SEARCH, OP_DUMP: begin
								if (!empty) begin
									state_q  <= S_SCAN;
									idx_q    <= '0;
									rd_ptr_q <= head_q;
									search_q <= (cmd.op == OP_SEARCH);
									held_v_q <= 1'b0;
								end
							end
							default: ;
						endcase
					end
				end
				S_POP: begin
					if (ofree) begin
						head_q  <= ptr_inc(head_q);
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (scan_go) begin
						if (match) begin
							held_v_q <= 1'b1;
						end
						if (lastent) begin
							state_q <= search_q ? S_FLUSH : S_IDLE;
						end else begin
							idx_q    <= idx_q + CNT_W'(1);
							rd_ptr_q <= ptr_inc(rd_ptr_q);
						end
					end
				end
				S_FLUSH: begin
					if (ofree) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_take) begin
			val_q <= cmd.value;
		end
		if (state_q == S_SCAN && scan_go && match) begin
			held_data_q <= ram_rdata;
			held_pos_q  <= idx_q + CNT_W'(1);
		end
		if (emit) begin
			out_status_q <= e_status;
			out_data_q   <= e_data;
			out_pos_q    <= e_pos;
			out_cnt_q    <= e_cnt;
			out_last_q   <= e_last;
		end
	end

	assign rsp_valid = out_valid_q;
	assign status    = out_status_q;
	assign data      = out_data_q;
	assign position  = out_pos_q;
	assign count     = out_cnt_q;
	assign last      = out_last_q;

endmodule

FILE: hw/rtl/fifo_queue_with_search.sv
`timescale 1ns / 1ps

// Queue of signed 32-bit values holding up to DEPTH entries, with search and dump.
// Requests arrive on the req channel (req_type, value) and are taken on a transfer
// when req_valid is high and req_stall is low. A two-entry request queue sits in
// front of the executing sequencer, so up to two requests are taken while it is busy.
// Results leave on the rsp channel (status, data, position, count, last) from an
// output register; a result is delivered on a transfer when rsp_valid is high and
// rsp_stall is low, and last marks the final result of each request.
// A request is held in the request queue register before it reaches the sequencer. A
// push or a refused request then shows its result from the output register and
// frees the sequencer at once; a pop waits in S_POP for the registered read of the
// entry memory. Search and dump walk the stored entries one per cycle while the
// receiver does not stall; a search ends with a final result from S_FLUSH. The
// single memory read port sets this rate.
// While the receiver stalls, the sequencer holds its position and resumes with no
// result lost; new requests keep filling the request queue until it is full.
// Reset empties the queue and clears all handshake state; the entry memory is not
// cleared, since only written entries are ever read.
module fifo_queue_with_search (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic [fqs_pkg::REQ_W-1:0]          req_type,
	input  logic signed [fqs_pkg::DATA_W-1:0]  value,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic [fqs_pkg::STAT_W-1:0]         status,
	output logic signed [fqs_pkg::DATA_W-1:0]  data,
	output logic [fqs_pkg::CNT_W-1:0]          position,
	output logic [fqs_pkg::CNT_W-1:0]          count,
	output logic                               last
);
	import fqs_pkg::*;

	logic              cmd_valid;
	logic              cmd_take;
	cmd_t              cmd;
	logic              ram_we;
	logic [PTR_W-1:0]  ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic              ram_re;
	logic [PTR_W-1:0]  ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	fqs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.value     (value),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd       (cmd)
	);

	fqs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd       (cmd),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.data      (data),
		.position  (position),
		.count     (count),
		.last      (last)
	);

	fqs_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

FILE: hw/rtl/fqs_checker.sv
`timescale 1ns / 1ps

module fqs_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               rsp_valid,
	input logic                               rsp_stall,
	input logic [fqs_pkg::STAT_W-1:0]         status,
	input logic signed [fqs_pkg::DATA_W-1:0]  data,
	input logic [fqs_pkg::CNT_W-1:0]          position,
	input logic [fqs_pkg::CNT_W-1:0]          count,
	input logic                               last
);
	import fqs_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(data)
			&& $stable(position) && $stable(count) && $stable(last))
		else $error("Stalled result changed.");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> last)
		else $error("Error status on a result that is not the last.");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> data == '0 && position == '0)
		else $error("Error status with nonzero data or position.");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && position != '0 |-> position <= count)
		else $error("Position beyond occupancy.");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> count <= CNT_W'(DEPTH))
		else $error("Occupancy beyond capacity.");

endmodule

bind fifo_queue_with_search fqs_checker u_fqs_checker (.*);
